// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the shelf rectangle allocator.
// Holds macro definitions only; the top level includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sra_pkg.sv
// Package of the shelf rectangle allocator: field widths, register indexes,
// request and result types shared by the other modules but sra_fifo. Depends on nothing.
`timescale 1ns / 1ps

package sra_pkg;

  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int PAD_W   = 8;
  localparam int AREA_W  = 25;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int CIDX_W  = 8;
  localparam int MAX_DIM = 4096;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_ATLAS_WIDTH  = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_ATLAS_HEIGHT = 8'd1;
  localparam logic [CIDX_W-1:0] CFG_GAP_PIXELS   = 8'd2;
  localparam logic [CIDX_W-1:0] CFG_SHELF_SLACK  = 8'd3;

  localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 13'd1024;
  localparam logic [PAD_W-1:0] GAP_PIXELS_RST   = 8'd1;
  localparam logic [PAD_W-1:0] SHELF_SLACK_RST  = 8'd2;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    JOB_ADD    = 2'd0,
    JOB_REJECT = 2'd1,
    JOB_CLEAR  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [DIM_W-1:0] atlas_w;
    logic [DIM_W-1:0] atlas_h;
    logic [PAD_W-1:0] gap;
    logic [PAD_W-1:0] slack;
  } cfg_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [DIM_W-1:0]  rect_h;
    logic [DIM_W-1:0]  need_w;
    logic [DIM_W-1:0]  need_h;
    logic [PROD_W-1:0] area;
  } job_t;

  typedef struct packed {
    logic [POS_W-1:0] top;
    logic [DIM_W-1:0] tall;
    logic [DIM_W-1:0] pen;
  } shelf_t;

  typedef struct packed {
    logic              placed;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [AREA_W-1:0] area_used;
  } res_t;

endpackage

// File: src/sra_fifo.sv
// Small register queue used between the front and back parts and on the
// result side of the shelf rectangle allocator. Depends on nothing.
`timescale 1ns / 1ps

module sra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/sra_front.sv
// Front part of the shelf rectangle allocator: accepts requests, screens
// them against the atlas size and queues jobs. Depends on sra_pkg, sra_fifo.
`timescale 1ns / 1ps

module sra_front
  import sra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             req_type,
  input  logic [DIM_W-1:0] rect_width,
  input  logic [DIM_W-1:0] rect_height,
  input  cfg_t             cfg,
  output logic             job_valid,
  input  logic             job_pop,
  output job_t             job
);

  logic [DIM_W:0]   need_w_wide, need_h_wide;
  logic [DIM_W:0]   span_w, span_h;
  logic             too_big;
  job_t             job_new;
  logic             job_empty;
  logic [$bits(job_t)-1:0] job_bits;

  assign need_w_wide = {1'b0, rect_width} + (DIM_W + 1)'(cfg.gap);
  assign need_h_wide = {1'b0, rect_height} + (DIM_W + 1)'(cfg.gap);
  assign span_w      = need_w_wide + (DIM_W + 1)'(cfg.gap);
  assign span_h      = need_h_wide + (DIM_W + 1)'(cfg.gap);

  assign too_big = (rect_width == '0) || (rect_height == '0) ||
                   (32'(rect_width) > MAX_DIM) || (32'(rect_height) > MAX_DIM) ||
                   (span_w > {1'b0, cfg.atlas_w}) || (span_h > {1'b0, cfg.atlas_h});

  // A request that passes the screen has both padded sizes within the
  // atlas, so they fit in the field width. The product is registered by
  // the queue before the back part adds it.
  always_comb begin
    job_new.rect_h = rect_height;
    job_new.need_w = need_w_wide[DIM_W-1:0];
    job_new.need_h = need_h_wide[DIM_W-1:0];
    job_new.area   = need_w_wide[DIM_W-1:0] * need_h_wide[DIM_W-1:0];
    if (req_type == REQ_CLEAR) begin
      job_new.kind = JOB_CLEAR;
    end else if (too_big) begin
      job_new.kind = JOB_REJECT;
    end else begin
      job_new.kind = JOB_ADD;
    end
  end

  sra_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (job_new),
    .full    (in_full),
    .pop     (job_pop),
    .rd_data (job_bits),
    .empty   (job_empty)
  );

  assign job       = job_t'(job_bits);
  assign job_valid = !job_empty;

endmodule

// File: src/sra_back.sv
// Back part of the shelf rectangle allocator: walks the shelf store one
// shelf a cycle, opens shelves and keeps the used area. Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_back
  import sra_pkg::*;
#(
  parameter int MAX_SHELVES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic job_valid,
  output logic job_pop,
  input  job_t job_in,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  job_t              job_r;
  job_t              cur;
  logic [CNT_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DIM_W-1:0]  next_top_r, next_top_nxt;
  logic [AREA_W-1:0] area_r, area_nxt, area_add;
  logic [AREA_W+1:0] area_sum;
  shelf_t            mem [MAX_SHELVES];
  shelf_t            rd_data_r, mem_wdata;
  logic [IDX_W-1:0]  rd_addr, mem_waddr;
  logic              mem_we;
  logic [DIM_W:0]    tall_hi, pen_end, new_end, new_pen;
  logic              shelf_fit, new_fit, try_new;

  // While idle the job comes straight from the queue; during a scan it is
  // the copy taken when the scan started.
  assign cur = (state_r == ST_IDLE) ? job_in : job_r;

  assign area_sum = {2'b0, area_r} + (AREA_W + 2)'(cur.area);
  assign area_add = (area_sum > (AREA_W + 2)'(AREA_MAX)) ? AREA_MAX
                                                          : area_sum[AREA_W-1:0];

  assign tall_hi   = {1'b0, cur.rect_h} + (DIM_W + 1)'(cfg.slack);
  assign pen_end   = {1'b0, rd_data_r.pen} + {1'b0, cur.need_w};
  assign shelf_fit = (rd_data_r.tall >= cur.rect_h) &&
                     ({1'b0, rd_data_r.tall} <= tall_hi) &&
                     (pen_end <= {1'b0, cfg.atlas_w});

  assign new_end = {1'b0, next_top_r} + {1'b0, cur.need_h};
  assign new_pen = (DIM_W + 1)'(cfg.gap) + {1'b0, cur.need_w};
  assign new_fit = (count_r != CNT_W'(MAX_SHELVES)) && (new_end <= {1'b0, cfg.atlas_h});

  assign idx_inc = idx_r + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    next_top_nxt = next_top_r;
    area_nxt     = area_r;
    job_pop      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    rd_addr      = '0;
    try_new      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid && !res_full) begin
          job_pop = 1'b1;
          case (job_in.kind)
            JOB_CLEAR: begin
              res_push     = 1'b1;
              count_nxt    = '0;
              next_top_nxt = DIM_W'(cfg.gap);
              area_nxt     = '0;
            end
            JOB_ADD: begin
              if (count_r == '0) begin
                try_new = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
                idx_nxt   = '0;
              end
            end
            default: begin
              res_push      = 1'b1;
              res.area_used = area_r;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (shelf_fit) begin
          res_push      = 1'b1;
          res.placed    = 1'b1;
          res.pos_x     = rd_data_r.pen[POS_W-1:0];
          res.pos_y     = rd_data_r.top;
          res.area_used = area_add;
          area_nxt      = area_add;
          mem_we        = 1'b1;
          mem_waddr     = idx_r[IDX_W-1:0];
          mem_wdata     = rd_data_r;
          mem_wdata.pen = pen_end[DIM_W-1:0];
          state_nxt     = ST_IDLE;
        end else if (idx_inc < count_r) begin
          idx_nxt = idx_inc;
          rd_addr = idx_inc[IDX_W-1:0];
        end else begin
          try_new   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // No existing shelf took the rectangle: open one below the last if it fits, else report no placement.
    if (try_new) begin
      res_push = 1'b1;
      if (new_fit) begin
        res.placed     = 1'b1;
        res.pos_x      = POS_W'(cfg.gap);
        res.pos_y      = next_top_r[POS_W-1:0];
        res.area_used  = area_add;
        area_nxt       = area_add;
        mem_we         = 1'b1;
        mem_waddr      = count_r[IDX_W-1:0];
        mem_wdata.top  = next_top_r[POS_W-1:0];
        mem_wdata.tall = cur.rect_h;
        mem_wdata.pen  = new_pen[DIM_W-1:0];
        count_nxt      = count_r + CNT_W'(1);
        next_top_nxt   = new_end[DIM_W-1:0];
      end else begin
        res.area_used = area_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      count_r    <= '0;
      next_top_r <= DIM_W'(GAP_PIXELS_RST);
      area_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      count_r    <= count_nxt;
      next_top_r <= next_top_nxt;
      area_r     <= area_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: src/shelf_rect_allocator_top.sv
// Top level of the shelf rectangle allocator: configuration registers, the
// front and back parts and the result queue. Depends on sra_pkg, sra_fifo,
// sra_front, sra_back and assert_macros.svh.
//
// Requests enter through a queue port: in_push with in_req_type (0 add a
// rectangle, 1 clear all shelves), in_rect_width and in_rect_height; a
// request is taken when in_push is high and in_full is low. Results leave
// through a second queue port: while out_empty is low the oldest result sits
// on out_placed, out_pos_x, out_pos_y and out_area_used, and out_pop takes it.
// The cfg_ port writes atlas width, atlas height, padding and shelf slack;
// cfg_ready is always high. The user must write only while the block is idle;
// the block does not enforce this. A request is held in the front queue until
// the back part takes it. A clear, a screened-out add or an add with no
// shelves yet is finished as it is taken, so its result shows in the next
// cycle, and such requests can follow one a cycle while the result queue has
// room; an add against open shelves reads the store one entry a cycle and takes
// no new request meanwhile. Up to two requests wait ahead of the back part
// and two results behind it; when out_pop is held low the result queue fills,
// the back part stops and in_full rises. Reset empties both queues, clears the
// shelf count and used area and sets the next shelf top to the padding reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shelf_rect_allocator_top
  import sra_pkg::*;
#(
  parameter int MAX_SHELVES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_req_type,
  input  logic [DIM_W-1:0]  in_rect_width,
  input  logic [DIM_W-1:0]  in_rect_height,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_placed,
  output logic [POS_W-1:0]  out_pos_x,
  output logic [POS_W-1:0]  out_pos_y,
  output logic [AREA_W-1:0] out_area_used,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  logic job_valid, job_pop;
  job_t job;
  logic res_push, res_full;
  res_t res, res_head;
  logic [$bits(res_t)-1:0] res_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atlas_w <= ATLAS_WIDTH_RST;
      cfg_r.atlas_h <= ATLAS_HEIGHT_RST;
      cfg_r.gap     <= GAP_PIXELS_RST;
      cfg_r.slack   <= SHELF_SLACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATLAS_WIDTH:  cfg_r.atlas_w <= cfg_data;
        CFG_ATLAS_HEIGHT: cfg_r.atlas_h <= cfg_data;
        CFG_GAP_PIXELS:   cfg_r.gap     <= cfg_data[PAD_W-1:0];
        CFG_SHELF_SLACK:  cfg_r.slack   <= cfg_data[PAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sra_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .req_type    (in_req_type),
    .rect_width  (in_rect_width),
    .rect_height (in_rect_height),
    .cfg         (cfg_r),
    .job_valid   (job_valid),
    .job_pop     (job_pop),
    .job         (job)
  );

  sra_back #(
    .MAX_SHELVES (MAX_SHELVES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_in    (job),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  sra_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_bits),
    .empty   (out_empty)
  );

  assign res_head      = res_t'(res_bits);
  assign out_placed    = res_head.placed;
  assign out_pos_x     = res_head.pos_x;
  assign out_pos_y     = res_head.pos_y;
  assign out_area_used = res_head.area_used;

  // The back part only starts a request when the result queue has room.
  `ASSERT_ALWAYS(a_res_room, clk, rst_n, !(res_push && res_full), "result pushed into full queue")
  `ASSERT_ALWAYS(a_job_pop, clk, rst_n, !(job_pop && !job_valid), "job taken from empty queue")
  `ASSERT_ALWAYS(a_placed_area, clk, rst_n, !(res_push && res.placed && res.area_used == '0), "placement without area")
  `ASSERT_NEXT(a_res_shows, clk, rst_n, res_push, !out_empty, "pushed result not visible")

endmodule

// File: verif/shelf_checker.sv
// Checker for the shelf rectangle allocator: watches the request, result and
// register channels, predicts each result and compares it field by field.
// Depends on sra_pkg for field widths, register indexes and the result type.
`timescale 1ns / 1ps

module shelf_checker
  import sra_pkg::*;
#(
  parameter int MAX_SHELVES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic              in_req_type,
  input  logic [DIM_W-1:0]  in_rect_width,
  input  logic [DIM_W-1:0]  in_rect_height,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic              out_placed,
  input  logic [POS_W-1:0]  out_pos_x,
  input  logic [POS_W-1:0]  out_pos_y,
  input  logic [AREA_W-1:0] out_area_used,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  cfg_t              atlas_cfg;
  shelf_t            shelves [MAX_SHELVES];
  int                shelf_count;
  logic [DIM_W-1:0]  next_top;
  logic [AREA_W-1:0] area_sum;
  res_t              placements_due [$];
  int                result_no;

  initial begin
    fail_count = 0;
    pending    = 0;
    result_no  = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] result %0d: %s got %0d, want %0d", $time, result_no, what, got, want);
    fail_count++;
  endtask

  // Shelf first fit: reuse the first shelf tall enough but within the slack
  // whose pen still has room, else open a new shelf at the next free top.
  task automatic predict_request(input logic kind, input logic [DIM_W-1:0] w_in,
                                 input logic [DIM_W-1:0] h_in, output res_t r);
    int     w;
    int     h;
    int     gap;
    int     need_w;
    int     need_h;
    int     i;
    longint sum;
    w      = int'(w_in);
    h      = int'(h_in);
    gap    = int'(atlas_cfg.gap);
    need_w = w + gap;
    need_h = h + gap;
    r      = '0;
    if (kind == REQ_CLEAR) begin
      shelf_count = 0;
      next_top    = DIM_W'(atlas_cfg.gap);
      area_sum    = '0;
    end else if (!(w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM ||
                   w + 2 * gap > int'(atlas_cfg.atlas_w) ||
                   h + 2 * gap > int'(atlas_cfg.atlas_h))) begin
      for (i = 0; i < shelf_count && !r.placed; i++) begin
        if (int'(shelves[i].tall) >= h && int'(shelves[i].tall) <= h + int'(atlas_cfg.slack) &&
            int'(shelves[i].pen) + need_w <= int'(atlas_cfg.atlas_w)) begin
          r.placed       = 1'b1;
          r.pos_x        = shelves[i].pen[POS_W-1:0];
          r.pos_y        = shelves[i].top;
          shelves[i].pen = DIM_W'(int'(shelves[i].pen) + need_w);
        end
      end
      if (!r.placed && shelf_count < MAX_SHELVES &&
          int'(next_top) + need_h <= int'(atlas_cfg.atlas_h)) begin
        shelves[shelf_count].top  = next_top[POS_W-1:0];
        shelves[shelf_count].tall = h_in;
        shelves[shelf_count].pen  = DIM_W'(gap + need_w);
        r.placed    = 1'b1;
        r.pos_x     = POS_W'(gap);
        r.pos_y     = next_top[POS_W-1:0];
        shelf_count = shelf_count + 1;
        next_top    = DIM_W'(int'(next_top) + need_h);
      end
      if (r.placed) begin
        sum      = longint'(area_sum) + longint'(need_w) * longint'(need_h);
        area_sum = (sum > longint'(AREA_MAX)) ? AREA_MAX : AREA_W'(sum);
      end
    end
    r.area_used = area_sum;
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      atlas_cfg.atlas_w = ATLAS_WIDTH_RST;
      atlas_cfg.atlas_h = ATLAS_HEIGHT_RST;
      atlas_cfg.gap     = GAP_PIXELS_RST;
      atlas_cfg.slack   = SHELF_SLACK_RST;
      shelf_count       = 0;
      next_top          = DIM_W'(GAP_PIXELS_RST);
      area_sum          = '0;
      placements_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATLAS_WIDTH:  atlas_cfg.atlas_w = cfg_data;
          CFG_ATLAS_HEIGHT: atlas_cfg.atlas_h = cfg_data;
          CFG_GAP_PIXELS:   atlas_cfg.gap     = cfg_data[PAD_W-1:0];
          CFG_SHELF_SLACK:  atlas_cfg.slack   = cfg_data[PAD_W-1:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        got = {out_placed, out_pos_x, out_pos_y, out_area_used};
        if (placements_due.size() == 0) begin
          report_mismatch("result with no request waiting, area_used", got.area_used, 0);
        end else begin
          want = placements_due.pop_front();
          if (got.placed !== want.placed)
            report_mismatch("placed", got.placed, want.placed);
          if (got.pos_x !== want.pos_x)
            report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y !== want.pos_y)
            report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.area_used !== want.area_used)
            report_mismatch("area_used", got.area_used, want.area_used);
        end
        result_no++;
      end
      if (in_push && !in_full) begin
        predict_request(in_req_type, in_rect_width, in_rect_height, want);
        placements_due = {placements_due, want};
      end
    end
    pending = placements_due.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top of the shelf rectangle allocator: clock, reset, request and
// register stimulus, random result stalls and the verdict. Depends on sra_pkg,
// shelf_rect_allocator_top and shelf_checker.
`timescale 1ns / 1ps

module tb
  import sra_pkg::*;
();

  localparam int LIMIT_CYCLES = 600000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_req_type;
  logic [DIM_W-1:0]  in_rect_width;
  logic [DIM_W-1:0]  in_rect_height;
  logic              out_empty;
  logic              out_pop;
  logic              out_placed;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;
  logic [AREA_W-1:0] out_area_used;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]  cfg_data;
  int                fail_count;
  int                pending;
  int                cycles;
  bit                calm;

  shelf_rect_allocator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_req_type(in_req_type),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_empty(out_empty), .out_pop(out_pop), .out_placed(out_placed),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_area_used(out_area_used),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  shelf_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_req_type(in_req_type),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_empty(out_empty), .out_pop(out_pop), .out_placed(out_placed),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_area_used(out_area_used),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // The result side stalls on its own, except during the calm stretch.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop <= calm || ($urandom_range(99) >= 22);
    end
  end

  // The request stays on the ports until a rising edge sees in_full low.
  task automatic send_req(input logic kind, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] h);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 22) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push        <= 1'b1;
    in_req_type    <= kind;
    in_rect_width  <= w;
    in_rect_height <= h;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_random(input int mw, input int mh);
    int               pick;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    pick = $urandom_range(99);
    w    = DIM_W'($urandom_range(mw, 1));
    h    = DIM_W'($urandom_range(mh, 1));
    if (pick < 3)
      send_req(REQ_CLEAR, DIM_W'($urandom), DIM_W'($urandom));
    else if (pick < 6)
      send_req(REQ_ADD, DIM_W'($urandom), DIM_W'($urandom));
    else if (pick < 9)
      send_req(REQ_ADD, pick[0] ? '0 : w, pick[0] ? h : '0);
    else
      send_req(REQ_ADD, w, h);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    int aw;
    int ah;
    int gp;
    int sl;
    int mw;
    int mh;
    int n;
    int p;
    int k;
    rst_n          = 1'b0;
    calm           = 1'b0;
    in_push        = 1'b0;
    in_req_type    = REQ_ADD;
    in_rect_width  = '0;
    in_rect_height = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests against the reset settings: 1024 x 1024, gap 1, slack 2.
    send_req(REQ_ADD, 13'd10, 13'd20);
    send_req(REQ_ADD, 13'd30, 13'd20);
    send_req(REQ_ADD, 13'd5, 13'd18);
    send_req(REQ_ADD, 13'd5, 13'd17);
    send_req(REQ_ADD, 13'd5, 13'd21);
    send_req(REQ_ADD, 13'd0, 13'd10);
    send_req(REQ_ADD, 13'd10, 13'd0);
    send_req(REQ_ADD, 13'd0, 13'd0);
    send_req(REQ_ADD, 13'h1FFF, 13'h1FFF);
    send_req(REQ_ADD, 13'd4097, 13'd5);
    send_req(REQ_ADD, 13'd5, 13'd4097);
    send_req(REQ_ADD, 13'd4096, 13'd4096);
    send_req(REQ_ADD, 13'd1023, 13'd5);
    send_req(REQ_ADD, 13'd1022, 13'd5);
    send_req(REQ_ADD, 13'd5, 13'd1022);
    send_req(REQ_ADD, 13'd1000, 13'd20);
    send_req(REQ_ADD, 13'd900, 13'd19);
    send_req(REQ_CLEAR, 13'h1FFF, 13'h1FFF);
    send_req(REQ_ADD, 13'd1, 13'd1);
    send_req(REQ_ADD, 13'd1, 13'd1);
    send_req(REQ_CLEAR, 13'd0, 13'd0);
    send_req(REQ_ADD, 13'd1022, 13'd1022);
    send_req(REQ_ADD, 13'd1, 13'd1);

    for (p = 1; p <= 9; p++) begin
      wait_idle();
      case (p)
        1: begin aw = 1024; ah = 1024; gp = 1;   sl = 2;   mw = 200;  mh = 24;   n = 300; end
        2: begin aw = 4096; ah = 4096; gp = 255; sl = 255; mw = 1500; mh = 600;  n = 150; end
        3: begin aw = 1;    ah = 1;    gp = 0;   sl = 0;   mw = 2;    mh = 2;    n = 60;  end
        // Many distinct heights with no slack fill the shelf store.
        4: begin aw = 4096; ah = 4096; gp = 0;   sl = 0;   mw = 40;   mh = 100;  n = 300; end
        // Coordinates past 12 bits and a saturating area sum.
        5: begin aw = 8191; ah = 8191; gp = 0;   sl = 3;   mw = 4096; mh = 4096; n = 120; end
        7: begin aw = 300;  ah = 200;  gp = 3;   sl = 0;   mw = 60;   mh = 20;   n = 250; end
        9: begin aw = 1024; ah = 1024; gp = 1;   sl = 2;   mw = 1024; mh = 1024; n = 170; end
        default: begin
          aw = $urandom_range(4096, 16);
          ah = $urandom_range(4096, 16);
          gp = $urandom_range(255);
          sl = $urandom_range(255);
          mw = aw / 3 + 1;
          mh = ah / 6 + 1;
          n  = 200;
        end
      endcase
      write_reg(CFG_ATLAS_WIDTH, DIM_W'(aw));
      write_reg(CFG_ATLAS_HEIGHT, DIM_W'(ah));
      // The upper data bits of the 8-bit registers are dropped by the block.
      write_reg(CFG_GAP_PIXELS, {5'($urandom), 8'(gp)});
      write_reg(CFG_SHELF_SLACK, {5'($urandom), 8'(sl)});
      write_reg(CIDX_W'($urandom_range(255, 4)), DIM_W'($urandom));
      @(negedge clk);
      cfg_valid <= 1'b0;
      calm = (p == 1);
      for (k = 0; k < n; k++) begin
        if (p == 4 && k == n / 2)
          wait_idle();
        send_random(mw, mh);
      end
    end

    calm = 1'b0;
    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
